@@ design/srhf_pkg.sv @@
// ----------------------------------------------------------------------------
// srhf_pkg
// Shared widths, defaults and helper functions for the sample resolve and
// hole fill block.
// ----------------------------------------------------------------------------
package srhf_pkg;

  localparam int MAX_ROW_PIXELS = 1024;

  localparam int SUM_W    = 16;
  localparam int CNT_W    = 8;
  localparam int CHAN_W   = 8;
  localparam int STREAK_W = 8;
  localparam int WEIGHT_W = 7;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int LINE_W   = COLOUR_W + STREAK_W;

  localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;
  localparam logic [STREAK_W-1:0] STREAK_ONE = 8'd1;

  // max(100 / s, 1) with s == 0 counted as 1, written out as thresholds
  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [STREAK_W-1:0] s);
    logic [WEIGHT_W-1:0] w;
    if (s <= 8'd1)       w = 7'd100;
    else if (s == 8'd2)  w = 7'd50;
    else if (s == 8'd3)  w = 7'd33;
    else if (s == 8'd4)  w = 7'd25;
    else if (s == 8'd5)  w = 7'd20;
    else if (s == 8'd6)  w = 7'd16;
    else if (s == 8'd7)  w = 7'd14;
    else if (s == 8'd8)  w = 7'd12;
    else if (s == 8'd9)  w = 7'd11;
    else if (s == 8'd10) w = 7'd10;
    else if (s == 8'd11) w = 7'd9;
    else if (s == 8'd12) w = 7'd8;
    else if (s <= 8'd14) w = 7'd7;
    else if (s <= 8'd16) w = 7'd6;
    else if (s <= 8'd20) w = 7'd5;
    else if (s <= 8'd25) w = 7'd4;
    else if (s <= 8'd33) w = 7'd3;
    else if (s <= 8'd50) w = 7'd2;
    else                 w = 7'd1;
    return w;
  endfunction

  function automatic logic [STREAK_W-1:0] streak_inc(input logic [STREAK_W-1:0] s);
    return (s == STREAK_MAX) ? STREAK_MAX : s + STREAK_ONE;
  endfunction

endpackage

@@ design/srhf_if.sv @@
// ----------------------------------------------------------------------------
// srhf_if
// Valid/ready channels for pixel sums in and resolved pixels out.
// ----------------------------------------------------------------------------
interface srhf_in_if;
  logic                         valid;
  logic                         ready;
  logic [srhf_pkg::SUM_W-1:0]   red_sum;
  logic [srhf_pkg::SUM_W-1:0]   green_sum;
  logic [srhf_pkg::SUM_W-1:0]   blue_sum;
  logic [srhf_pkg::CNT_W-1:0]   sample_count;
  logic [srhf_pkg::STREAK_W-1:0] streak_in;
  logic                         row_end;
  logic                         frame_start;

  modport source (output valid, red_sum, green_sum, blue_sum, sample_count,
                  streak_in, row_end, frame_start, input ready);
  modport sink (input valid, red_sum, green_sum, blue_sum, sample_count,
                streak_in, row_end, frame_start, output ready);
endinterface

interface srhf_out_if;
  logic                        valid;
  logic                        ready;
  logic [srhf_pkg::CHAN_W-1:0] out_red;
  logic [srhf_pkg::CHAN_W-1:0] out_green;
  logic [srhf_pkg::CHAN_W-1:0] out_blue;
  logic                        was_sampled;

  modport source (output valid, out_red, out_green, out_blue, was_sampled,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, was_sampled,
                output ready);
endinterface

@@ design/sample_resolve_hole_fill_top.sv @@
// ----------------------------------------------------------------------------
// sample_resolve_hole_fill_top
// Resolves accumulated RGB sample sums to pixel bytes in raster order and
// fills empty pixels from their left and upper neighbors. The previous row's
// colors and streaks live in a line RAM.
//
//   channel   direction  handshake      payload
//   pix_in    sink       valid/ready    red/green/blue sums, count, streak,
//                                       row_end, frame_start
//   pix_out   source     valid/ready    out_red/green/blue, was_sampled
//
// Each pixel passes through a line RAM read, a setup state, the divider
// (radix-2 steps of the three lanes in parallel, then their done flag), a
// write-back state and the idle state that takes the next transaction; a new
// pixel is accepted only after the previous one is written back. A full
// output register stalls the write-back until it is taken.
// Reset is synchronous; line RAM entries are tracked by a fill count, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module sample_resolve_hole_fill_top #(
  parameter int MAX_ROW_PIXELS = srhf_pkg::MAX_ROW_PIXELS
) (
  input  logic       clk,
  input  logic       rst,
  srhf_in_if.sink    pix_in,
  srhf_out_if.source pix_out
);

  localparam int COL_W  = $clog2(MAX_ROW_PIXELS);
  localparam int FILL_W = $clog2(MAX_ROW_PIXELS + 1);
  localparam int SW     = srhf_pkg::STREAK_W;
  localparam int CH     = srhf_pkg::CHAN_W;
  localparam int NW     = srhf_pkg::SUM_W;
  localparam int DW     = srhf_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_PREP  = 5'b00100,
    S_DIV   = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state, state_next;

  // captured transaction
  logic [NW-1:0] red_sum, green_sum, blue_sum;
  logic [DW-1:0] sample_count;
  logic [SW-1:0] streak_in;
  logic          row_end;

  // raster position and neighbor state
  logic [COL_W-1:0]             column_index;
  logic [FILL_W-1:0]            fill_count;
  logic                         first_row_flag;
  logic                         left_present;
  logic [srhf_pkg::COLOUR_W-1:0] left_colour;
  logic [SW-1:0]                left_streak;
  logic [SW-1:0]                streak;

  // line RAM
  logic [srhf_pkg::LINE_W-1:0] line_rdata;
  logic [srhf_pkg::LINE_W-1:0] line_wdata;
  logic                        line_we;

  // prep datapath
  logic [srhf_pkg::COLOUR_W-1:0] uc;
  logic [SW-1:0]                 us, ls;
  logic                          up;
  logic [srhf_pkg::WEIGHT_W-1:0] lw, uw;
  logic [NW-1:0]                 num_r, num_g, num_b;
  logic [DW-1:0]                 den;
  logic [SW-1:0]                 streak_calc;

  logic                 div_start;
  logic [2:0]           div_done;
  logic [CH-1:0]        q_r, q_g, q_b;
  logic [srhf_pkg::COLOUR_W-1:0] colour;
  logic                 accept;
  logic                 out_free;

  assign accept   = pix_in.valid && pix_in.ready;
  assign out_free = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (pix_in.valid) state_next = S_READ;
      S_READ:  state_next = S_PREP;
      S_PREP:  state_next = S_DIV;
      S_DIV:   if (&div_done) state_next = S_WRITE;
      S_WRITE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_sum      <= pix_in.red_sum;
      green_sum    <= pix_in.green_sum;
      blue_sum     <= pix_in.blue_sum;
      sample_count <= pix_in.sample_count;
      streak_in    <= pix_in.streak_in;
      row_end      <= pix_in.row_end;
    end
  end

  srhf_ram #(
    .WIDTH (srhf_pkg::LINE_W),
    .DEPTH (MAX_ROW_PIXELS)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (column_index),
    .wdata (line_wdata),
    .raddr (column_index),
    .rdata (line_rdata)
  );

  // neighbor selection and divider operands, line RAM data valid in prep
  assign uc = line_rdata[srhf_pkg::LINE_W-1:SW];
  assign us = line_rdata[SW-1:0];
  assign ls = (left_streak == '0) ? srhf_pkg::STREAK_ONE : left_streak;
  // entries are written as a prefix of the row, so the fill count marks them
  assign up = !first_row_flag && ({1'b0, column_index} < fill_count);
  assign lw = srhf_pkg::weight_of(ls);
  assign uw = srhf_pkg::weight_of(us);

  always_comb begin
    num_r       = '0;
    num_g       = '0;
    num_b       = '0;
    den         = DW'(1);
    streak_calc = srhf_pkg::STREAK_ONE;
    priority if (sample_count != '0) begin
      num_r       = red_sum;
      num_g       = green_sum;
      num_b       = blue_sum;
      den         = sample_count;
      streak_calc = (streak_in == '0) ? srhf_pkg::STREAK_ONE : streak_in;
    end else if (up && left_present) begin
      num_r = NW'(left_colour[3*CH-1:2*CH]) * NW'(lw) + NW'(uc[3*CH-1:2*CH]) * NW'(uw);
      num_g = NW'(left_colour[2*CH-1:CH]) * NW'(lw)   + NW'(uc[2*CH-1:CH]) * NW'(uw);
      num_b = NW'(left_colour[CH-1:0]) * NW'(lw)      + NW'(uc[CH-1:0]) * NW'(uw);
      den   = DW'(lw) + DW'(uw);
      streak_calc = srhf_pkg::streak_inc((ls < us) ? ls : us);
    end else if (up) begin
      num_r       = NW'(uc[3*CH-1:2*CH]);
      num_g       = NW'(uc[2*CH-1:CH]);
      num_b       = NW'(uc[CH-1:0]);
      streak_calc = srhf_pkg::streak_inc(us);
    end else if (left_present) begin
      num_r       = NW'(left_colour[3*CH-1:2*CH]);
      num_g       = NW'(left_colour[2*CH-1:CH]);
      num_b       = NW'(left_colour[CH-1:0]);
      streak_calc = srhf_pkg::streak_inc(ls);
    end else begin
      streak_calc = srhf_pkg::STREAK_ONE;
    end
  end

  assign div_start = (state == S_PREP);

  srhf_div u_div_r (
    .clk (clk), .rst (rst), .start (div_start), .dividend (num_r),
    .divisor (den), .done (div_done[0]), .quotient (q_r)
  );
  srhf_div u_div_g (
    .clk (clk), .rst (rst), .start (div_start), .dividend (num_g),
    .divisor (den), .done (div_done[1]), .quotient (q_g)
  );
  srhf_div u_div_b (
    .clk (clk), .rst (rst), .start (div_start), .dividend (num_b),
    .divisor (den), .done (div_done[2]), .quotient (q_b)
  );

  assign colour     = {q_r, q_g, q_b};
  assign line_we    = (state == S_WRITE) && out_free;
  assign line_wdata = {colour, streak};

  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      streak <= streak_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index   <= '0;
      fill_count     <= '0;
      first_row_flag <= 1'b1;
      left_present   <= 1'b0;
      left_colour    <= '0;
      left_streak    <= '0;
    end else if (accept && pix_in.frame_start) begin
      column_index   <= '0;
      first_row_flag <= 1'b1;
      left_present   <= 1'b0;
    end else if (line_we) begin
      left_colour <= colour;
      left_streak <= streak;
      if ({1'b0, column_index} >= fill_count) begin
        fill_count <= FILL_W'(column_index) + 1'b1;
      end
      if (row_end) begin
        column_index   <= '0;
        first_row_flag <= 1'b0;
        left_present   <= 1'b0;
      end else begin
        left_present <= 1'b1;
        // an overlong row keeps reusing the last entry
        if (column_index != COL_W'(MAX_ROW_PIXELS - 1)) begin
          column_index <= column_index + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (line_we) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      pix_out.out_red     <= q_r;
      pix_out.out_green   <= q_g;
      pix_out.out_blue    <= q_b;
      pix_out.was_sampled <= (sample_count != '0);
    end
  end

endmodule

@@ design/srhf_ram.sv @@
// ----------------------------------------------------------------------------
// srhf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srhf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/srhf_div.sv @@
// ----------------------------------------------------------------------------
// srhf_div
// Restoring radix-2 divider, one quotient bit per cycle, quotient
// saturated to one colour byte.
// ----------------------------------------------------------------------------
module srhf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [srhf_pkg::SUM_W-1:0]  dividend,
  input  logic [srhf_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [srhf_pkg::CHAN_W-1:0] quotient
);

  localparam int NW = srhf_pkg::SUM_W;
  localparam int DW = srhf_pkg::CNT_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [CW-1:0] steps;
  logic          busy;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem, quo[NW-1]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CW'(NW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits the divisor width
      if (fits) begin
        rem <= DW'(shifted - {1'b0, den});
      end else begin
        rem <= shifted[DW-1:0];
      end
      quo <= {quo[NW-2:0], fits};
    end
  end

  assign quotient = (|quo[NW-1:srhf_pkg::CHAN_W]) ? '1 : quo[srhf_pkg::CHAN_W-1:0];

endmodule
